>>> rtl/asd_pkg.sv
// Shared types, constants and codes for the accelerometer step detector.
`default_nettype none

package asd_pkg;

    // Averaging window depth (2..16).
    localparam int WINDOW     = 4;
    localparam int WIN_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MAG_W      = 17;
    localparam int SUM_W      = MAG_W + $clog2(WINDOW);
    localparam int ROOT_W     = 16;
    localparam int REM_W      = ROOT_W + 1;
    localparam int SQ_W       = 32;
    localparam int ROOT_STEPS = 16;
    localparam int ITER_W     = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL   = 1'd1;
    localparam logic [15:0] STEP_THRESHOLD_RST = 16'd4710;
    localparam logic [15:0] MIN_INTERVAL_RST   = 16'd280;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_Z,
        S_ACC,
        S_ROOT,
        S_WIN,
        S_DECIDE,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    // Controller to datapath commands.
    typedef struct packed {
        logic  load;      // capture input item, clear per-item state
        logic  mul_en;    // square the selected axis into the product reg
        t_axis mul_sel;
        logic  acc_en;    // add product into sum of squares
        logic  acc_clr;   // start sum of squares from the product
        logic  root_en;   // one digit of the square root
        logic  win_en;    // push magnitude, update running sum
        logic  decide_en; // threshold crossing and interval check
        logic  emit;      // load the output register
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic out_valid;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/asd_in_if.sv
// Input channel: one accelerometer sample per item.
`default_nettype none

interface asd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [31:0] time_ms;
    logic               sample_ok;

    modport source (output valid, accel_x, accel_y, accel_z, time_ms, sample_ok,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, sample_ok,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/asd_out_if.sv
// Output channel: step flag and running step count per item.
`default_nettype none

interface asd_out_if;
    logic        valid;
    logic        ready;
    logic        step_seen;
    logic [31:0] steps_total;

    modport source (output valid, step_seen, steps_total, input ready);
    modport sink   (input valid, step_seen, steps_total, output ready);
endinterface

`default_nettype wire

>>> rtl/asd_ctrl.sv
// Sequencing state machine for the step detector.
`default_nettype none

module asd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_ok,
    input  wire logic          i_out_ready,
    input  wire asd_pkg::t_stat i_stat,
    output logic               o_in_ready,
    output asd_pkg::t_cmd      o_cmd
);

    asd_pkg::t_state                r_state, n_state;
    logic [asd_pkg::ITER_W-1:0]     r_iter, n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asd_pkg::S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_iter        = r_iter;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.mul_sel = asd_pkg::AXIS_X;
        unique case (r_state)
            asd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // bad sample skips all processing
                    n_state = i_in_ok ? asd_pkg::S_MUL_X : asd_pkg::S_EMIT;
                end
            end
            asd_pkg::S_MUL_X: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = asd_pkg::AXIS_X;
                n_state       = asd_pkg::S_MUL_Y;
            end
            asd_pkg::S_MUL_Y: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = asd_pkg::AXIS_Y;
                o_cmd.acc_en  = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_state       = asd_pkg::S_MUL_Z;
            end
            asd_pkg::S_MUL_Z: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = asd_pkg::AXIS_Z;
                o_cmd.acc_en  = 1'b1;
                n_state       = asd_pkg::S_ACC;
            end
            asd_pkg::S_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_iter       = '0;
                n_state      = asd_pkg::S_ROOT;
            end
            asd_pkg::S_ROOT: begin
                o_cmd.root_en = 1'b1;
                n_iter        = r_iter + 1'b1;
                if (r_iter == asd_pkg::ITER_W'(asd_pkg::ROOT_STEPS - 1)) begin
                    n_state = asd_pkg::S_WIN;
                end
            end
            asd_pkg::S_WIN: begin
                o_cmd.win_en = 1'b1;
                n_state      = asd_pkg::S_DECIDE;
            end
            asd_pkg::S_DECIDE: begin
                o_cmd.decide_en = 1'b1;
                n_state         = asd_pkg::S_EMIT;
            end
            asd_pkg::S_EMIT: begin
                if (!i_stat.out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = asd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = asd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/asd_dp.sv
// Datapath: squares, digit-serial square root, window sum, step decision.
`default_nettype none

module asd_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire asd_pkg::t_cmd                   i_cmd,
    input  wire logic signed [15:0]              i_accel_x,
    input  wire logic signed [15:0]              i_accel_y,
    input  wire logic signed [15:0]              i_accel_z,
    input  wire logic        [31:0]              i_time_ms,
    input  wire logic                            i_cfg_we,
    input  wire logic [asd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [asd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_out_ready,
    output asd_pkg::t_stat                       o_stat,
    output logic                                 o_out_valid,
    output logic                                 o_step_seen,
    output logic [31:0]                          o_steps_total
);

    // Configuration
    logic [15:0] r_thr;
    logic [15:0] r_min_int;

    // Per-item registers
    logic signed [15:0]              r_x, r_y, r_z;
    logic [31:0]                     r_now;
    logic [asd_pkg::SQ_W-1:0]        r_prod;
    logic [asd_pkg::SQ_W-1:0]        r_acc;
    logic [asd_pkg::ROOT_W-1:0]      r_q;
    logic [asd_pkg::REM_W-1:0]       r_rem;
    logic                            r_seen;

    // Detector state
    logic [asd_pkg::MAG_W-1:0]       r_win [asd_pkg::WINDOW];
    logic [asd_pkg::WIN_W-1:0]       r_slot;
    logic [asd_pkg::SUM_W-1:0]       r_sum;
    logic                            r_was_above;
    logic [31:0]                     r_last;
    logic [31:0]                     r_cnt;

    // Output register
    logic                            r_out_valid;
    logic                            r_out_seen;
    logic [31:0]                     r_out_total;

    logic signed [15:0]              mul_op;
    logic signed [31:0]              mul_res;
    logic [asd_pkg::REM_W+1:0]       rem_try;
    logic [asd_pkg::REM_W+1:0]       trial;
    logic [asd_pkg::MAG_W-1:0]       mag;
    logic [asd_pkg::MAG_W-1:0]       old_mag;
    logic [asd_pkg::SUM_W-1:0]       lim;
    logic [31:0]                     elapsed;
    logic                            above;
    logic                            fire;

    always_comb begin
        unique case (i_cmd.mul_sel)
            asd_pkg::AXIS_X: mul_op = r_x;
            asd_pkg::AXIS_Y: mul_op = r_y;
            asd_pkg::AXIS_Z: mul_op = r_z;
            default:         mul_op = r_x;
        endcase
    end

    assign mul_res = 32'(mul_op) * 32'(mul_op);

    // One result bit per step: bring down two radicand bits, try q*4+1.
    assign rem_try = {r_rem, r_acc[asd_pkg::SQ_W-1 -: 2]};
    assign trial   = {1'b0, r_q, 2'b01};

    assign mag     = asd_pkg::MAG_W'(r_q);
    assign old_mag = r_win[r_slot];

    // floor(sum / WINDOW) > thr  <=>  sum >= (thr + 1) * WINDOW
    assign lim     = asd_pkg::SUM_W'(asd_pkg::SUM_W'(r_thr) + 1'b1)
                   * asd_pkg::SUM_W'(asd_pkg::WINDOW);
    assign above   = (r_sum >= lim);
    assign elapsed = r_now - r_last;
    assign fire    = above && !r_was_above && (elapsed > {16'd0, r_min_int});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= asd_pkg::STEP_THRESHOLD_RST;
            r_min_int   <= asd_pkg::MIN_INTERVAL_RST;
            r_slot      <= '0;
            r_sum       <= '0;
            r_was_above <= 1'b0;
            r_last      <= '0;
            r_cnt       <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < asd_pkg::WINDOW; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    asd_pkg::REG_STEP_THRESHOLD: r_thr     <= i_cfg_data;
                    asd_pkg::REG_MIN_INTERVAL:   r_min_int <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.load) begin
                r_seen <= 1'b0;
            end

            if (i_cmd.win_en) begin
                r_win[r_slot] <= mag;
                r_sum         <= r_sum - asd_pkg::SUM_W'(old_mag)
                               + asd_pkg::SUM_W'(mag);
                if (r_slot == asd_pkg::WIN_W'(asd_pkg::WINDOW - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end

            if (i_cmd.decide_en) begin
                r_was_above <= above;
                if (fire) begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_last <= r_now;
                    r_seen <= 1'b1;
                end
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_accel_x;
            r_y   <= i_accel_y;
            r_z   <= i_accel_z;
            r_now <= i_time_ms;
            r_q   <= '0;
            r_rem <= '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= asd_pkg::SQ_W'(unsigned'(mul_res));
        end
        if (i_cmd.acc_en) begin
            r_acc <= i_cmd.acc_clr ? r_prod : r_acc + r_prod;
        end
        if (i_cmd.root_en) begin
            r_acc <= {r_acc[asd_pkg::SQ_W-3:0], 2'b00};
            if (rem_try >= trial) begin
                r_rem <= asd_pkg::REM_W'(rem_try - trial);
                r_q   <= {r_q[asd_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem <= asd_pkg::REM_W'(rem_try);
                r_q   <= {r_q[asd_pkg::ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.emit) begin
            r_out_seen  <= r_seen;
            r_out_total <= r_cnt;
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_out_valid      = r_out_valid;
    assign o_step_seen      = r_out_seen;
    assign o_steps_total    = r_out_total;

endmodule

`default_nettype wire

>>> rtl/accel_step_detector_core.sv
// Top level of the accelerometer step detector: controller, datapath, checks.
// A good sample steps through three squares on the single shared 16x16 multiplier, accumulate,
//   the 16-step square root loop, window update, decision and emit; a bad sample goes straight
//   to emit. No new sample is accepted until the current one has been emitted.
// The output register lets a finished result wait while the next item is accepted.
// Reset (i_rst_n low, synchronous) clears the window, counters and flags, loads default regs.
`default_nettype none

module accel_step_detector_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    asd_in_if.sink                              i_item,
    asd_out_if.source                           o_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [asd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [asd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    asd_pkg::t_cmd  cmd;
    asd_pkg::t_stat stat;
    logic           in_ready;

    // Controller: sequences one item at a time, in_ready only while idle.
    asd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_ok     (i_item.sample_ok),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_cmd       (cmd)
    );

    // Datapath: squares -> isqrt -> running window sum -> crossing test.
    asd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_accel_x     (i_item.accel_x),
        .i_accel_y     (i_item.accel_y),
        .i_accel_z     (i_item.accel_z),
        .i_time_ms     (i_item.time_ms),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (o_res.ready),
        .o_stat        (stat),
        .o_out_valid   (o_res.valid),
        .o_step_seen   (o_res.step_seen),
        .o_steps_total (o_res.steps_total)
    );

    assign i_item.ready = in_ready;

    // A result is only loaded when the output register is free or draining.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_res.valid || o_res.ready))
        else $error("result loaded over a pending result");

    // One item in flight: no accept in the cycle after an accept.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("second item accepted while busy");

    // Datapath phases never overlap.
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.mul_en && !cmd.acc_en, cmd.root_en, cmd.win_en,
                  cmd.decide_en, cmd.emit}))
        else $error("overlapping datapath commands");

endmodule

`default_nettype wire
